// File: rtl/core/rs1024_checksum_engine_defines.svh
// Assertion macros used by the checksum engine job queue
`ifndef RS1024_CHECKSUM_ENGINE_DEFINES_SVH
`define RS1024_CHECKSUM_ENGINE_DEFINES_SVH

// check a property at every rising clock edge outside reset
`define RS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that a condition leads to a consequence in the following cycle
`define RS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rs1024_pkg.sv
// Types, constants and polymod step for the RS1024 checksum engine
package rs1024_pkg;

  localparam int unsigned WORD_W = 10;
  localparam int unsigned RES_W = 30;
  localparam int unsigned GEN_N = 10;
  localparam int unsigned PREFIX_N = 6;
  localparam int unsigned ZERO_STEPS = 3;
  localparam int unsigned CHK_WORDS = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 16;

  localparam logic [RES_W-1:0] GEN_TAB [GEN_N] = '{
    30'h00E0E040, 30'h01C1C080, 30'h03838100, 30'h07070200, 30'h0E0E0009,
    30'h1C0C2412, 30'h38086C24, 30'h3090FC48, 30'h21B1F890, 30'h03F3F120
  };

  localparam logic [WORD_W-1:0] PREFIX_CHARS [PREFIX_N] = '{
    10'd115, 10'd104, 10'd97, 10'd109, 10'd105, 10'd114
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SEND
  } back_state_e;

  typedef struct packed {
    logic              mode;
    logic [RES_W-1:0]  residue;
  } job_t;

  function automatic logic [RES_W-1:0] poly_update(input logic [RES_W-1:0] r,
                                                   input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] top;
    logic [RES_W-1:0]  n;
    top = r[RES_W-1:RES_W-WORD_W];
    n = {r[RES_W-WORD_W-1:0], w};
    for (int j = 0; j < GEN_N; j++) begin
      if (top[j]) begin
        n = n ^ GEN_TAB[j];
      end
    end
    return n;
  endfunction

  function automatic logic [RES_W-1:0] prefix_residue();
    logic [RES_W-1:0] r;
    r = RES_W'(1);
    for (int i = 0; i < PREFIX_N; i++) begin
      r = poly_update(r, PREFIX_CHARS[i]);
    end
    return r;
  endfunction

  localparam logic [RES_W-1:0] PREFIX_RESIDUE = prefix_residue();

endpackage

// File: rtl/core/rs1024_front.sv
// Front end: accept words, update the residue, queue a job at each last word
module rs1024_front
  import rs1024_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              s_valid_i,
  input  logic [WORD_W-1:0] s_word_i,
  input  logic              s_last_i,
  output logic              s_ready_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output job_t              q_job_o
);

  logic             mode_q;
  logic [RES_W-1:0] res_q;
  logic [RES_W-1:0] res_d;
  logic [RES_W-1:0] res_upd;
  logic             accept;

  assign s_ready_o = !q_full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign res_upd   = poly_update(res_q, s_word_i);

  assign q_push_o        = accept && s_last_i;
  assign q_job_o.mode    = mode_q;
  assign q_job_o.residue = res_upd;

  always_comb begin
    res_d = res_q;
    if (accept) begin
      res_d = s_last_i ? PREFIX_RESIDUE : res_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      res_q  <= PREFIX_RESIDUE;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      res_q <= res_d;
    end
  end

endmodule

// File: rtl/core/rs1024_queue.sv
// Job queue between front and back end
module rs1024_queue
  import rs1024_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`include "rs1024_checksum_engine_defines.svh"

  `RS_ASSERT(a_cnt_bound, (cnt_q <= CntW'(Depth)), "queue count above depth")
  `RS_ASSERT(a_no_overflow, (push_i |-> (!full_o || pop_i)), "push into full queue")
  `RS_ASSERT(a_no_underflow, (pop_i |-> !empty_o), "pop from empty queue")
  `RS_ASSERT_NEXT(a_cnt_up, (push_i && !pop_i), (cnt_q == $past(cnt_q) + CntW'(1)), "count not raised")

endmodule

// File: rtl/core/rs1024_back.sv
// Back end: finish checksum or verify, emit result words
module rs1024_back
  import rs1024_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  job_t              q_job_i,
  output logic              q_pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [WORD_W-1:0] m_word_o,
  output logic              m_ok_o,
  output logic              m_last_o
);

  localparam int unsigned StepW = $clog2(ZERO_STEPS);
  localparam int unsigned IdxW = $clog2(CHK_WORDS);

  back_state_e      state_q, state_d;
  logic             mode_q;
  logic             ok_q;
  logic [RES_W-1:0] res_q;
  logic [RES_W-1:0] res_upd;
  logic [StepW-1:0] step_q;
  logic [IdxW-1:0]  idx_q;
  logic             calc_done;
  logic             out_fire;
  logic [WORD_W-1:0] word_sel;

  assign res_upd   = poly_update(res_q, '0);
  assign calc_done = (step_q == StepW'(ZERO_STEPS - 1));
  assign out_fire  = m_valid_o && m_ready_i;

  always_comb begin
    case (idx_q)
      IdxW'(0): word_sel = res_q[3*WORD_W-1:2*WORD_W];
      IdxW'(1): word_sel = res_q[2*WORD_W-1:WORD_W];
      default:  word_sel = res_q[WORD_W-1:0];
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = q_job_i.mode ? ST_SEND : ST_CALC;
        end
      end
      ST_CALC: begin
        if (calc_done) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_fire && m_last_o) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o   = 1'b0;
    m_valid_o = 1'b0;
    m_word_o  = '0;
    m_ok_o    = 1'b0;
    m_last_o  = 1'b0;
    case (state_q)
      ST_IDLE: q_pop_o = !q_empty_i;
      ST_SEND: begin
        m_valid_o = 1'b1;
        m_word_o  = mode_q ? '0 : word_sel;
        m_ok_o    = mode_q && ok_q;
        m_last_o  = mode_q || (idx_q == IdxW'(CHK_WORDS - 1));
      end
      default: q_pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      mode_q <= q_job_i.mode;
      ok_q   <= (q_job_i.residue == RES_W'(1));
      res_q  <= q_job_i.residue;
    end else if (state_q == ST_CALC) begin
      res_q <= calc_done ? (res_upd ^ RES_W'(1)) : res_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        step_q <= '0;
        idx_q  <= '0;
      end else begin
        if (state_q == ST_CALC) begin
          step_q <= step_q + StepW'(1);
        end
        if (out_fire) begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
    end
  end

endmodule

// File: rtl/core/rs1024_checksum_engine.sv
// Accepted words update the registered residue. Create mode: 3 polymod steps after the job
// leaves the queue, then 3 words, one per cycle while m_axis_tready is high. The back end
// takes no new job until the current one's last result word is out. One input word per cycle;
// the queue (QueueDepth entries) absorbs back-end time, input stalls only when it is full.
// Reset: residue loads the prefix polymod, mode is create, queue and back end go empty.
module rs1024_checksum_engine
  import rs1024_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [9:0] word, rest ignored
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [9:0] checksum_word, rest zero
  output logic                 m_axis_tuser,   // [0] checksum_ok
  output logic                 m_axis_tlast
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  job_t              q_wr_job;
  job_t              q_rd_job;
  logic [WORD_W-1:0] m_word;

  rs1024_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_word_i    (s_axis_tdata[WORD_W-1:0]),
    .s_last_i    (s_axis_tlast),
    .s_ready_o   (s_axis_tready),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (q_wr_job)
  );

  rs1024_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rd_job),
    .empty_o (q_empty)
  );

  rs1024_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_job_i   (q_rd_job),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_word_o  (m_word),
    .m_ok_o    (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(M_TDATA_W - WORD_W){1'b0}}, m_word};

endmodule

// File: verif/rs1024_checksum_monitor.sv
// Polymod helpers and the checker that predicts and compares checksum engine results
package rs1024_tb_pkg;

  localparam bit MODE_CREATE = 1'b0;
  localparam bit MODE_VERIFY = 1'b1;

  localparam logic [29:0] GEN_POLY [10] = '{
    30'h00E0E040, 30'h01C1C080, 30'h03838100, 30'h07070200, 30'h0E0E0009,
    30'h1C0C2412, 30'h38086C24, 30'h3090FC48, 30'h21B1F890, 30'h03F3F120
  };

  function automatic logic [29:0] rs_step(input logic [29:0] r, input logic [9:0] w);
    logic [29:0] acc;
    acc = {r[19:0], w};
    for (int b = 0; b < 10; b++) begin
      if (r[20 + b]) begin
        acc = acc ^ GEN_POLY[b];
      end
    end
    return acc;
  endfunction

  // "shamir" customization string
  function automatic logic [29:0] prefix_value();
    logic [29:0] r;
    logic [9:0]  text [6];
    text = '{10'd115, 10'd104, 10'd97, 10'd109, 10'd105, 10'd114};
    r = 30'd1;
    for (int k = 0; k < 6; k++) begin
      r = rs_step(r, text[k]);
    end
    return r;
  endfunction

  // flush three zero words and fold in the final constant
  function automatic logic [29:0] seal_value(input logic [29:0] r);
    logic [29:0] acc;
    acc = r;
    for (int k = 0; k < 3; k++) begin
      acc = rs_step(acc, 10'd0);
    end
    return acc ^ 30'd1;
  endfunction

endpackage

module rs1024_checksum_monitor
  import rs1024_pkg::*;
  import rs1024_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 m_axis_tuser,
  input  logic                 m_axis_tlast,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [9:0] sum_word;
    logic       ok;
    logic       eor;
  } sum_item_t;

  sum_item_t   sums_due [$];
  sum_item_t   got;
  sum_item_t   due;
  logic [29:0] residue_q;
  logic [29:0] sealed;
  logic        mode_q;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      residue_q = prefix_value();
      mode_q = MODE_CREATE;
      sums_due.delete();
      fail_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.sum_word = m_axis_tdata[9:0];
        got.ok = m_axis_tuser;
        got.eor = m_axis_tlast;
        if (sums_due.size() == 0) begin
          $error("unexpected result word: checksum_word %0d checksum_ok %0d end_of_run %0d",
                 got.sum_word, got.ok, got.eor);
          fail_count_o++;
        end else begin
          due = sums_due.pop_front();
          if (got.sum_word !== due.sum_word) begin
            $error("checksum_word: expected %0d, actual %0d", due.sum_word, got.sum_word);
            fail_count_o++;
          end
          if (got.ok !== due.ok) begin
            $error("checksum_ok: expected %0d, actual %0d", due.ok, got.ok);
            fail_count_o++;
          end
          if (got.eor !== due.eor) begin
            $error("end_of_run: expected %0d, actual %0d", due.eor, got.eor);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        residue_q = rs_step(residue_q, s_axis_tdata[9:0]);
        if (s_axis_tlast) begin
          if (mode_q == MODE_VERIFY) begin
            sums_due.push_back('{10'd0, residue_q == 30'd1, 1'b1});
          end else begin
            sealed = seal_value(residue_q);
            sums_due.push_back('{sealed[29:20], 1'b0, 1'b0});
            sums_due.push_back('{sealed[19:10], 1'b0, 1'b0});
            sums_due.push_back('{sealed[9:0], 1'b0, 1'b1});
          end
          residue_q = prefix_value();
        end
      end
      if (cfg_we_i) begin
        mode_q = cfg_wdata_i;
      end
    end
    pending_o = sums_due.size();
  end

endmodule

// File: verif/rs1024_checksum_engine_tb.sv
// Stimulus, reset and verdict for the RS1024 checksum engine testbench
module rs1024_checksum_engine_tb;
  import rs1024_pkg::*;
  import rs1024_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_TARGET = 260;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 20;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  int                   fail_count;
  int                   pending;

  bit          gaps_on;
  int          words_sent;
  logic [29:0] stream_res;

  rs1024_checksum_engine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  rs1024_checksum_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end
  end

  task automatic put_word(input logic [9:0] w, input logic last, input logic [5:0] pad);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pad, w};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    stream_res = last ? prefix_value() : rs_step(stream_res, w);
    words_sent++;
  endtask

  // hold input until every result is out, then let the back end settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // n data words; with_sum appends the three checksum words, spoil corrupts one of them
  task automatic send_msg(input int n, input bit with_sum, input bit spoil);
    logic [29:0] sealed;
    logic [29:0] flip;
    for (int k = 0; k < n; k++) begin
      put_word(10'($urandom_range(0, 1023)), !with_sum && k == n - 1, 6'd0);
    end
    if (with_sum) begin
      flip = spoil ? (30'd1 << $urandom_range(0, 29)) : 30'd0;
      sealed = seal_value(stream_res) ^ flip;
      put_word(sealed[29:20], 1'b0, 6'd0);
      put_word(sealed[19:10], 1'b0, 6'd0);
      put_word(sealed[9:0], 1'b1, 6'd0);
    end
  endtask

  initial begin
    logic [29:0] sealed;
    logic        mode;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    gaps_on = 1'b1;
    words_sent = 0;
    stream_res = prefix_value();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // create-mode extremes, padding bits set, back-to-back messages
    write_mode(MODE_CREATE);
    put_word(10'd0, 1'b1, 6'd0);
    put_word(10'd1023, 1'b1, 6'd0);
    put_word(10'h155, 1'b0, 6'd0);
    put_word(10'h2AA, 1'b1, 6'd0);
    put_word(10'h3FF, 1'b0, 6'h3F);
    put_word(10'h000, 1'b1, 6'h2A);
    send_msg(4, 1'b0, 1'b0);

    // mode switched in the middle of a message: mode at the last word wins
    put_word(10'h0AB, 1'b0, 6'd0);
    put_word(10'h3C3, 1'b0, 6'd0);
    write_mode(MODE_VERIFY);
    sealed = seal_value(stream_res);
    put_word(sealed[29:20], 1'b0, 6'd0);
    put_word(sealed[19:10], 1'b0, 6'd0);
    put_word(sealed[9:0], 1'b1, 6'd0);

    // verify: good, corrupted, single word, checksum only
    send_msg(3, 1'b1, 1'b0);
    send_msg(2, 1'b1, 1'b1);
    put_word(10'd1023, 1'b1, 6'd0);
    send_msg(0, 1'b1, 1'b0);
    drain();

    for (int phase = 0; words_sent < WORD_TARGET; phase++) begin
      if (words_sent > WORD_TARGET * 3 / 4) begin
        gaps_on = 1'b0;
      end
      mode = (phase % 2 == 0) ? MODE_CREATE : MODE_VERIFY;
      write_mode(mode);
      repeat ($urandom_range(4, 9)) begin
        if (mode == MODE_VERIFY) begin
          case ($urandom_range(0, 7))
            0: send_msg($urandom_range(1, 6), 1'b0, 1'b0);
            1: send_msg($urandom_range(0, 6), 1'b1, 1'b1);
            default: send_msg($urandom_range(0, 6), 1'b1, 1'b0);
          endcase
        end else begin
          send_msg($urandom_range(1, 8), 1'b0, 1'b0);
        end
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/rs1024_pkg.sv
rtl/core/rs1024_front.sv
rtl/core/rs1024_queue.sv
rtl/core/rs1024_back.sv
rtl/core/rs1024_checksum_engine.sv
verif/rs1024_checksum_monitor.sv
verif/rs1024_checksum_engine_tb.sv
